### rtl/stt_pkg.sv
// Shared types and defaults for the software ticker table.
package stt_pkg;

    localparam int TICKER_COUNT_DEF = 16;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic [31:0] delay;
        logic [31:0] period;
        logic [31:0] repeats;
        logic [7:0]  tag;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

endpackage

### rtl/stt_mem.sv
// Ticker entry memory with one write port, one registered read port and per-entry valid bits.
module stt_mem #(
    parameter int TICKER_COUNT = stt_pkg::TICKER_COUNT_DEF,
    parameter int IW = (TICKER_COUNT > 1) ? $clog2(TICKER_COUNT) : 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_en,
    input  logic [IW-1:0]   wr_addr,
    input  stt_pkg::entry_t wr_data,
    input  logic            rd_en,
    input  logic [IW-1:0]   rd_addr,
    output stt_pkg::entry_t rd_data
);

    stt_pkg::entry_t        mem [TICKER_COUNT];
    logic [TICKER_COUNT-1:0] vld_reg;
    stt_pkg::entry_t        rd_q_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // An entry never written reads as its reset value of zero.
    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

### rtl/stt_walker.sv
// Tick sequencer: reads, updates and writes back each entry and queues expiry results.
module stt_walker #(
    parameter int TICKER_COUNT = stt_pkg::TICKER_COUNT_DEF,
    parameter int IW = (TICKER_COUNT > 1) ? $clog2(TICKER_COUNT) : 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            tick_start,
    output logic            busy,
    output logic            rd_en,
    output logic [IW-1:0]   rd_addr,
    input  stt_pkg::entry_t rd_data,
    output logic            wr_en,
    output logic [IW-1:0]   wr_addr,
    output stt_pkg::entry_t wr_data,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [3:0]      m_fired_slot,
    output logic [7:0]      m_fired_tag,
    output logic            m_last
);

    stt_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   cur_reg, cur_next;
    logic            pend_vld_reg, pend_vld_next;
    logic [3:0]      pend_slot_reg, pend_slot_next;
    logic [7:0]      pend_tag_reg, pend_tag_next;
    logic            out_vld_reg, out_vld_next;
    logic [3:0]      out_slot_reg, out_slot_next;
    logic [7:0]      out_tag_reg, out_tag_next;
    logic            out_last_reg, out_last_next;

    stt_pkg::entry_t upd;
    logic [31:0]     dec;
    logic            expire;
    logic            emit;
    logic            out_free;
    logic            stall;
    logic            at_end;

    always_comb begin
        dec    = rd_data.delay - 32'd1;
        expire = (rd_data.delay != 32'd0) && (dec == 32'd0);
        upd    = rd_data;
        if (rd_data.delay != 32'd0) begin
            upd.delay = dec;
            if (expire && (rd_data.repeats != 32'd0)) begin
                if (!rd_data.repeats[31]) begin
                    upd.repeats = rd_data.repeats - 32'd1;
                end
                upd.delay = rd_data.period;
            end
        end
    end

    assign emit     = expire && (rd_data.tag != 8'd0);
    assign out_free = !out_vld_reg || m_ready;
    assign stall    = emit && pend_vld_reg && !out_free;
    assign at_end   = (cur_reg == IW'(TICKER_COUNT - 1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stt_pkg::ST_IDLE: begin
                if (tick_start) begin
                    state_next = stt_pkg::ST_WALK;
                end
            end
            stt_pkg::ST_WALK: begin
                if (!stall && at_end) begin
                    state_next = stt_pkg::ST_FLUSH;
                end
            end
            stt_pkg::ST_FLUSH: begin
                if (!pend_vld_reg || out_free) begin
                    state_next = stt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_en          = 1'b0;
        rd_addr        = cur_reg;
        wr_en          = 1'b0;
        cur_next       = cur_reg;
        pend_vld_next  = pend_vld_reg;
        pend_slot_next = pend_slot_reg;
        pend_tag_next  = pend_tag_reg;
        out_vld_next   = out_vld_reg && !m_ready;
        out_slot_next  = out_slot_reg;
        out_tag_next   = out_tag_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            stt_pkg::ST_IDLE: begin
                if (tick_start) begin
                    rd_en    = 1'b1;
                    rd_addr  = '0;
                    cur_next = '0;
                end
            end
            stt_pkg::ST_WALK: begin
                if (!stall) begin
                    wr_en = 1'b1;
                    if (emit) begin
                        if (pend_vld_reg) begin
                            out_vld_next  = 1'b1;
                            out_slot_next = pend_slot_reg;
                            out_tag_next  = pend_tag_reg;
                            out_last_next = 1'b0;
                        end
                        pend_vld_next  = 1'b1;
                        pend_slot_next = 4'(cur_reg);
                        pend_tag_next  = rd_data.tag;
                    end
                    if (!at_end) begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_reg + IW'(1);
                        cur_next = cur_reg + IW'(1);
                    end
                end
            end
            stt_pkg::ST_FLUSH: begin
                if (pend_vld_reg && out_free) begin
                    out_vld_next  = 1'b1;
                    out_slot_next = pend_slot_reg;
                    out_tag_next  = pend_tag_reg;
                    out_last_next = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stt_pkg::ST_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        pend_slot_reg <= pend_slot_next;
        pend_tag_reg  <= pend_tag_next;
        out_slot_reg  <= out_slot_next;
        out_tag_reg   <= out_tag_next;
        out_last_reg  <= out_last_next;
    end

    assign busy         = (state_reg != stt_pkg::ST_IDLE);
    assign wr_addr      = cur_reg;
    assign wr_data      = upd;
    assign m_valid      = out_vld_reg;
    assign m_fired_slot = out_slot_reg;
    assign m_fired_tag  = out_tag_reg;
    assign m_last       = out_last_reg;

endmodule

### rtl/software_ticker_table_core.sv
// Top level of the software ticker table: request decode, memory write arbitration and hierarchy.
//
//  channel | direction | ports                                          | handshake
//  --------+-----------+------------------------------------------------+----------------
//  request | in        | s_req_type s_slot s_start_delay s_reload_period| s_valid/s_ready
//          |           | s_repeat_count s_payload_tag                   |
//  result  | out       | m_fired_slot m_fired_tag m_last                | m_valid/m_ready
//
// A load transaction writes its entry straight into the memory.
// A tick transaction makes one memory read per entry, overlapped with the write-back of the
// previous entry, and then a flush step marks and hands over the final result.
// A tick stalls only while the output register is full and a held expiry has to move into it.
// Reset is synchronous, marks every entry as never written and needs no clearing pass.
module software_ticker_table_core #(
    parameter int TICKER_COUNT = stt_pkg::TICKER_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [3:0]         s_slot,
    input  logic [31:0]        s_start_delay,
    input  logic [31:0]        s_reload_period,
    input  logic signed [31:0] s_repeat_count,
    input  logic [7:0]         s_payload_tag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_fired_slot,
    output logic [7:0]         m_fired_tag,
    output logic               m_last
);

    localparam int IW = (TICKER_COUNT > 1) ? $clog2(TICKER_COUNT) : 1;

    logic            busy;
    logic            s_fire;
    logic            tick_start;
    logic            load_wr;
    logic            rd_en;
    logic [IW-1:0]   rd_addr;
    stt_pkg::entry_t rd_data;
    logic            walk_wr_en;
    logic [IW-1:0]   walk_wr_addr;
    stt_pkg::entry_t walk_wr_data;
    logic            mem_wr_en;
    logic [IW-1:0]   mem_wr_addr;
    stt_pkg::entry_t mem_wr_data;
    stt_pkg::entry_t load_data;

    assign s_ready    = !busy;
    assign s_fire     = s_valid && s_ready;
    assign tick_start = s_fire && (s_req_type == stt_pkg::REQ_TICK);
    assign load_wr    = s_fire && (s_req_type == stt_pkg::REQ_LOAD)
                        && ({28'd0, s_slot} < 32'(TICKER_COUNT));

    always_comb begin
        load_data.delay   = s_start_delay;
        load_data.period  = s_reload_period;
        load_data.repeats = $unsigned(s_repeat_count);
        load_data.tag     = s_payload_tag;
    end

    assign mem_wr_en   = load_wr || walk_wr_en;
    assign mem_wr_addr = load_wr ? IW'(s_slot) : walk_wr_addr;
    assign mem_wr_data = load_wr ? load_data : walk_wr_data;

    stt_mem #(
        .TICKER_COUNT(TICKER_COUNT),
        .IW(IW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    stt_walker #(
        .TICKER_COUNT(TICKER_COUNT),
        .IW(IW)
    ) u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_start   (tick_start),
        .busy         (busy),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (walk_wr_en),
        .wr_addr      (walk_wr_addr),
        .wr_data      (walk_wr_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_fired_slot (m_fired_slot),
        .m_fired_tag  (m_fired_tag),
        .m_last       (m_last)
    );

endmodule

### rtl/stt_checker.sv
// Port-level assertions for the software ticker table, bound to the top level.
module stt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_req_type,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_fired_slot,
    input logic [7:0] m_fired_tag,
    input logic       m_last
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fired_slot)
                                && $stable(m_fired_tag) && $stable(m_last))
        else $error("result transaction changed while stalled");

    // A tick keeps the request side closed while the table is walked.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == stt_pkg::REQ_TICK) |=> !s_ready)
        else $error("request accepted during a tick walk");

    // A load completes in the cycle it is accepted.
    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == stt_pkg::REQ_LOAD) |=> s_ready)
        else $error("load transaction held the request side");

    // Only entries with a nonzero tag produce results.
    a_tag_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fired_tag != 8'd0))
        else $error("result transaction with an empty tag");

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered after reset");

endmodule

bind software_ticker_table_core stt_checker u_stt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_req_type   (s_req_type),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_fired_slot (m_fired_slot),
    .m_fired_tag  (m_fired_tag),
    .m_last       (m_last)
);

### tb/ticker_expiry_checker.sv
// Transaction monitor that predicts ticker expiries and compares them with the result channel.
`timescale 1ns / 1ps

module ticker_expiry_checker #(
    parameter int TICKER_COUNT = stt_pkg::TICKER_COUNT_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_req_type,
    input  logic [3:0]         s_slot,
    input  logic [31:0]        s_start_delay,
    input  logic [31:0]        s_reload_period,
    input  logic signed [31:0] s_repeat_count,
    input  logic [7:0]         s_payload_tag,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [3:0]         m_fired_slot,
    input  logic [7:0]         m_fired_tag,
    input  logic               m_last,
    output int                 mismatch_count,
    output int                 expiries_pending
);

    typedef struct {
        logic [3:0] slot;
        logic [7:0] tag;
        logic       last;
    } expiry_t;

    logic [31:0] delay_left   [TICKER_COUNT];
    logic [31:0] period_of    [TICKER_COUNT];
    logic [31:0] repeats_left [TICKER_COUNT];
    logic [7:0]  tag_of       [TICKER_COUNT];
    expiry_t     expiry_q[$];

    function automatic void tick_table();
        expiry_t fired[$];
        expiry_t e;
        for (int i = 0; i < TICKER_COUNT; i++) begin
            if (delay_left[i] != '0) begin
                delay_left[i] = delay_left[i] - 32'd1;
                if (delay_left[i] == '0) begin
                    if (repeats_left[i] != '0) begin
                        if (!repeats_left[i][31]) begin
                            repeats_left[i] = repeats_left[i] - 32'd1;
                        end
                        delay_left[i] = period_of[i];
                    end
                    if (tag_of[i] != '0) begin
                        e.slot = 4'(i);
                        e.tag  = tag_of[i];
                        e.last = 1'b0;
                        fired.push_back(e);
                    end
                end
            end
        end
        for (int k = 0; k < fired.size(); k++) begin
            e = fired[k];
            e.last = (k == fired.size() - 1);
            expiry_q.push_back(e);
        end
    endfunction

    always @(posedge aclk) begin : track
        expiry_t head;
        if (!aresetn) begin
            for (int i = 0; i < TICKER_COUNT; i++) begin
                delay_left[i]   = '0;
                period_of[i]    = '0;
                repeats_left[i] = '0;
                tag_of[i]       = '0;
            end
            expiry_q.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expiry_q.size() == 0) begin
                    $error("unexpected result: fired_slot %0d fired_tag %0d last %0b",
                           m_fired_slot, m_fired_tag, m_last);
                    mismatch_count++;
                end else begin
                    head = expiry_q.pop_front();
                    if (m_fired_slot !== head.slot) begin
                        $error("fired_slot: expected %0d, actual %0d", head.slot, m_fired_slot);
                        mismatch_count++;
                    end
                    if (m_fired_tag !== head.tag) begin
                        $error("fired_tag: expected %0d, actual %0d", head.tag, m_fired_tag);
                        mismatch_count++;
                    end
                    if (m_last !== head.last) begin
                        $error("last: expected %0b, actual %0b", head.last, m_last);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_req_type == stt_pkg::REQ_LOAD) begin
                    if (int'(s_slot) < TICKER_COUNT) begin
                        delay_left[s_slot]   = s_start_delay;
                        period_of[s_slot]    = s_reload_period;
                        repeats_left[s_slot] = s_repeat_count;
                        tag_of[s_slot]       = s_payload_tag;
                    end
                end else begin
                    tick_table();
                end
            end
        end
        expiries_pending <= expiry_q.size();
    end

endmodule

### tb/software_ticker_table_core_tb.sv
// Top of the ticker table testbench: clock, reset, request and result stimulus, and the verdict.
`timescale 1ns / 1ps

module software_ticker_table_core_tb;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 68;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic [3:0]         s_slot;
    logic [31:0]        s_start_delay;
    logic [31:0]        s_reload_period;
    logic signed [31:0] s_repeat_count;
    logic [7:0]         s_payload_tag;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_fired_slot;
    logic [7:0]         m_fired_tag;
    logic               m_last;

    int mismatch_count;
    int expiries_pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    bit hold_off_req = 1'b0;

    always #2 aclk = ~aclk;

    software_ticker_table_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_slot          (s_slot),
        .s_start_delay   (s_start_delay),
        .s_reload_period (s_reload_period),
        .s_repeat_count  (s_repeat_count),
        .s_payload_tag   (s_payload_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_fired_slot    (m_fired_slot),
        .m_fired_tag     (m_fired_tag),
        .m_last          (m_last)
    );

    ticker_expiry_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_slot           (s_slot),
        .s_start_delay    (s_start_delay),
        .s_reload_period  (s_reload_period),
        .s_repeat_count   (s_repeat_count),
        .s_payload_tag    (s_payload_tag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_fired_slot     (m_fired_slot),
        .m_fired_tag      (m_fired_tag),
        .m_last           (m_last),
        .mismatch_count   (mismatch_count),
        .expiries_pending (expiries_pending)
    );

    // A long hold-off lets the block fill up and stall its request channel.
    initial begin : receiver
        bit hold_off_done;
        hold_off_done = 1'b0;
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_done = 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("software_ticker_table_core verification failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_request(input logic req, input logic [3:0] slot,
                                input logic [31:0] dly, input logic [31:0] per,
                                input logic [31:0] rpt, input logic [7:0] tag);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_slot          <= slot;
        s_start_delay   <= dly;
        s_reload_period <= per;
        s_repeat_count  <= rpt;
        s_payload_tag   <= tag;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_load(input logic [3:0] slot, input logic [31:0] dly,
                             input logic [31:0] per, input logic [31:0] rpt,
                             input logic [7:0] tag);
        send_request(stt_pkg::REQ_LOAD, slot, dly, per, rpt, tag);
    endtask

    // Fields other than the request type are don't-care on a tick and get random values.
    task automatic send_tick();
        send_request(stt_pkg::REQ_TICK, 4'($urandom()), $urandom(), $urandom(), $urandom(),
                     8'($urandom()));
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_stall);
        logic [31:0] dly;
        logic [31:0] per;
        logic [31:0] rpt;
        logic [7:0]  tag;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 45) begin
                case ($urandom_range(9))
                    0:       dly = '0;
                    1:       dly = $urandom();
                    default: dly = $urandom_range(1, 4);
                endcase
                case ($urandom_range(9))
                    0, 1:    per = '0;
                    2:       per = $urandom();
                    default: per = $urandom_range(1, 5);
                endcase
                case ($urandom_range(5))
                    0:       rpt = 32'hFFFF_FFFF;
                    1:       rpt = $urandom();
                    2:       rpt = 32'h7FFF_FFFF;
                    default: rpt = $urandom_range(0, 3);
                endcase
                tag = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
                send_load(4'($urandom()), dly, per, rpt, tag);
            end else begin
                send_tick();
            end
        end
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_req_type      <= stt_pkg::REQ_TICK;
        s_slot          <= '0;
        s_start_delay   <= '0;
        s_reload_period <= '0;
        s_repeat_count  <= '0;
        s_payload_tag   <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_tick();
        send_load(4'd0,  32'd1, 32'd0, 32'd0, 8'hFF);
        send_load(4'd15, 32'd1, 32'd2, 32'hFFFF_FFFF, 8'h01);
        send_load(4'd3,  32'd1, 32'd1, 32'd1, 8'h00);
        send_load(4'd7,  32'd2, 32'd0, 32'd5, 8'h5A);
        send_load(4'd9,  32'd0, 32'd7, 32'd3, 8'h33);
        send_load(4'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 8'h80);
        send_load(4'd5,  32'd1, 32'd1, 32'h8000_0000, 8'h02);
        repeat (5) send_tick();
        send_load(4'd15, 32'd0, 32'd0, 32'd0, 8'h00);
        send_load(4'd5,  32'd0, 32'd0, 32'd0, 8'h00);
        send_tick();

        for (int i = 0; i < 16; i++) begin
            send_load(4'(i), 32'd1, 32'd1, 32'hFFFF_FFFF, 8'($urandom_range(1, 255)));
        end
        hold_off_req = 1'b1;
        repeat (6) send_tick();
        for (int i = 0; i < 16; i++) begin
            send_load(4'(i), 32'd0, 32'd0, 32'd0, 8'h00);
        end

        run_phase(0, 0);
        run_phase(65, 0);
        run_phase(0, 65);
        run_phase(37, 37);

        s_valid <= 1'b0;
        do @(posedge aclk); while (expiries_pending != 0);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && expiries_pending == 0) begin
            $display("software_ticker_table_core verification clean");
        end else begin
            $display("software_ticker_table_core verification failed");
        end
        $finish;
    end

endmodule
